// ===== rtl/core/pin_count_lru_replacer_unit_defines.svh =====
// assertion macros used by the replacer checker
`ifndef PIN_COUNT_LRU_REPLACER_UNIT_DEFINES_SVH
`define PIN_COUNT_LRU_REPLACER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PCLR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PCLR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pclr_pkg.sv =====
// shared types and codes of the pin-count lru replacer
`default_nettype none

package pclr_pkg;

   typedef enum logic [1:0] {
      CMD_PIN   = 2'd0,
      CMD_UNPIN = 2'd1,
      CMD_EVICT = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WAVE,
      ST_RESP
   } state_type;

   // broadcast controls from the sequencer to the order chain
   typedef struct packed {
      logic evict_shift;
      logic append;
      logic wave_start;
   } chain_ctl_type;

   localparam int CMD_W = 2;

endpackage

`default_nettype wire

// ===== rtl/core/pclr_cell.sv =====
// one slot of the lru order chain, position INDEX from the least recent end
`default_nettype none

module pclr_cell #(
   parameter int IDX_W = 6,
   parameter int LEN_W = 7,
   parameter int INDEX = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pclr_pkg::chain_ctl_type ctl,
   input  wire logic [IDX_W-1:0]       target,
   input  wire logic [LEN_W-1:0]       append_pos,
   input  wire logic                   token_in,
   input  wire logic                   rm_in,
   input  wire logic [IDX_W-1:0]       nxt_slot,
   input  wire logic                   nxt_valid,
   output logic      [IDX_W-1:0]       slot,
   output logic                        valid,
   output logic                        pass_out,
   output logic                        hit_out
);

   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             valid_ff, valid_in;
   logic             token_ff;
   logic             rm_ff;
   logic             hit;

   // once the removed frame is found every later slot pulls from its neighbor
   assign hit      = token_ff && valid_ff && (rm_ff || (slot_ff == target));
   assign pass_out = token_ff && valid_ff;
   assign hit_out  = hit;
   assign slot     = slot_ff;
   assign valid    = valid_ff;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (ctl.evict_shift || hit) begin
         slot_in  = nxt_slot;
         valid_in = nxt_valid;
      end else if (ctl.append && (append_pos == LEN_W'(INDEX))) begin
         slot_in  = target;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= IDX_W'(INDEX);
         valid_ff <= 1'b1;
         token_ff <= 1'b0;
         rm_ff    <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
         token_ff <= token_in;
         rm_ff    <= rm_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pclr_chain.sv =====
// row of order cells holding the unpinned frames, least recent at cell 0
`default_nettype none

module pclr_chain #(
   parameter int FRAMES = 64,
   parameter int IDX_W  = 6,
   parameter int LEN_W  = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pclr_pkg::chain_ctl_type ctl,
   input  wire logic [IDX_W-1:0]        target,
   input  wire logic [LEN_W-1:0]        append_pos,
   output logic      [IDX_W-1:0]        head_slot
);

   logic [IDX_W-1:0] slot  [FRAMES];
   logic             valid [FRAMES];
   logic             pass  [FRAMES];
   logic             hit   [FRAMES];

   genvar i;
   generate
      for (i = 0; i < FRAMES; i++) begin : g_cell
         logic             token_in;
         logic             rm_in;
         logic [IDX_W-1:0] nxt_slot;
         logic             nxt_valid;

         if (i == 0) begin : g_first
            assign token_in = ctl.wave_start;
            assign rm_in    = 1'b0;
         end else begin : g_rest
            assign token_in = pass[i-1];
            assign rm_in    = hit[i-1];
         end

         if (i == FRAMES - 1) begin : g_last
            assign nxt_slot  = '0;
            assign nxt_valid = 1'b0;
         end else begin : g_inner
            assign nxt_slot  = slot[i+1];
            assign nxt_valid = valid[i+1];
         end

         pclr_cell #(
            .IDX_W (IDX_W),
            .LEN_W (LEN_W),
            .INDEX (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .target     (target),
            .append_pos (append_pos),
            .token_in   (token_in),
            .rm_in      (rm_in),
            .nxt_slot   (nxt_slot),
            .nxt_valid  (nxt_valid),
            .slot       (slot[i]),
            .valid      (valid[i]),
            .pass_out   (pass[i]),
            .hit_out    (hit[i])
         );
      end
   endgenerate

   assign head_slot = slot[0];

endmodule

`default_nettype wire

// ===== rtl/core/pin_count_lru_replacer_unit.sv =====
// a transaction is accepted in idle, executes in exec and is held in resp with rsp_tvalid
// high until taken; a pin of a frame on the order list first passes through the wave state
// while the removal ripples through the order chain. one transaction at a time.
// reset is synchronous; after it a clear pass writes every entry of the frame table
// (count zero, listed), during which no transaction is accepted.
`default_nettype none

module pin_count_lru_replacer_unit #(
   parameter int FRAMES   = 64,
   parameter int PIN_BITS = 16,
   localparam int IDX_W    = $clog2(FRAMES),
   localparam int FRAME_W  = IDX_W + 1,
   localparam int LEN_W    = $clog2(FRAMES + 1),
   localparam int REQ_BITS = pclr_pkg::CMD_W + FRAME_W,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = IDX_W + PIN_BITS + LEN_W + 4,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // command, frame
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // victim_frame, none_free, pin_count, evictable, listed_frames, ignored, saturated
   output logic      [RSP_W-1:0] rsp_tdata
);

   pclr_pkg::state_type     state_ff, state_in;
   pclr_pkg::cmd_type       cmd_ff, cmd_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [LEN_W-1:0]        wave_ff, wave_in;
   logic [RSP_BITS-1:0]     rsp_data_ff, rsp_data_in;

   // frame table: {listed, pin count}
   logic [PIN_BITS:0]       mem [FRAMES];
   logic [PIN_BITS:0]       rd_ff;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [PIN_BITS:0]       wr_data;

   pclr_pkg::cmd_type       req_cmd;
   logic [FRAME_W-1:0]      req_frame;
   pclr_pkg::chain_ctl_type ctl;
   logic [IDX_W-1:0]        head_slot;

   logic                    in_range;
   logic [PIN_BITS-1:0]     pin_cur;
   logic                    listed_cur;
   logic [IDX_W-1:0]        victim;
   logic                    none_free;
   logic [PIN_BITS-1:0]     pin_new;
   logic                    evictable;
   logic                    ignored;
   logic                    saturated;

   assign req_cmd    = pclr_pkg::cmd_type'(req_tdata[pclr_pkg::CMD_W-1:0]);
   assign req_frame  = req_tdata[pclr_pkg::CMD_W +: FRAME_W];
   assign req_tready = (state_ff == pclr_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == pclr_pkg::ST_RESP);
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   assign in_range   = (frame_ff < FRAME_W'(FRAMES));
   assign pin_cur    = rd_ff[PIN_BITS-1:0];
   assign listed_cur = rd_ff[PIN_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // table is read at the address on the request port, so data is ready in exec
      rd_ff <= mem[req_frame[IDX_W-1:0]];
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      frame_in    = frame_ff;
      len_in      = len_ff;
      clr_in      = clr_ff;
      wave_in     = wave_ff;
      rsp_data_in = rsp_data_ff;
      wr_en       = 1'b0;
      wr_addr     = frame_ff[IDX_W-1:0];
      wr_data     = '0;
      ctl         = '0;
      victim      = '0;
      none_free   = 1'b0;
      pin_new     = '0;
      evictable   = 1'b0;
      ignored     = 1'b0;
      saturated   = 1'b0;
      unique case (state_ff)
         pclr_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b1, {PIN_BITS{1'b0}}};
            if (clr_ff == IDX_W'(FRAMES - 1)) begin
               state_in = pclr_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         pclr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_cmd;
               frame_in = req_frame;
               state_in = pclr_pkg::ST_EXEC;
            end
         end
         pclr_pkg::ST_EXEC: begin
            state_in = pclr_pkg::ST_RESP;
            if (cmd_ff == pclr_pkg::CMD_EVICT) begin
               if (len_ff == '0) begin
                  none_free = 1'b1;
               end else begin
                  victim          = head_slot;
                  ctl.evict_shift = 1'b1;
                  len_in          = len_ff - 1'b1;
                  wr_en           = 1'b1;
                  wr_addr         = head_slot;
                  wr_data         = '0;
               end
            end else if (!in_range) begin
               ignored = 1'b1;
            end else begin
               case (cmd_ff)
                  pclr_pkg::CMD_PIN: begin
                     if (&pin_cur) begin
                        saturated = 1'b1;
                        pin_new   = pin_cur;
                     end else begin
                        pin_new = pin_cur + 1'b1;
                     end
                     wr_en   = 1'b1;
                     wr_data = {1'b0, pin_new};
                     if (listed_cur) begin
                        ctl.wave_start = 1'b1;
                        len_in         = len_ff - 1'b1;
                        wave_in        = '0;
                        state_in       = pclr_pkg::ST_WAVE;
                     end
                  end
                  pclr_pkg::CMD_UNPIN: begin
                     if (pin_cur == '0) begin
                        ignored = 1'b1;
                     end else begin
                        pin_new = pin_cur - 1'b1;
                        wr_en   = 1'b1;
                        if ((pin_new == '0) && !listed_cur) begin
                           ctl.append = 1'b1;
                           len_in     = len_ff + 1'b1;
                           wr_data    = {1'b1, pin_new};
                        end else begin
                           wr_data = {listed_cur, pin_new};
                        end
                     end
                  end
                  default: begin
                     pin_new = pin_cur;
                  end
               endcase
               evictable = (pin_new == '0);
            end
            rsp_data_in = {saturated, ignored, len_in, evictable, pin_new, none_free, victim};
         end
         pclr_pkg::ST_WAVE: begin
            // the removal token sits in cell wave_ff; the last listed cell is old length - 1
            wave_in = wave_ff + 1'b1;
            if (wave_ff == len_ff) begin
               state_in = pclr_pkg::ST_RESP;
            end
         end
         pclr_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = pclr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pclr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pclr_pkg::ST_CLEAR;
         len_ff   <= LEN_W'(FRAMES);
         clr_ff   <= '0;
         wave_ff  <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         clr_ff   <= clr_in;
         wave_ff  <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      frame_ff    <= frame_in;
      rsp_data_ff <= rsp_data_in;
   end

   pclr_chain #(
      .FRAMES (FRAMES),
      .IDX_W  (IDX_W),
      .LEN_W  (LEN_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .target     (frame_ff[IDX_W-1:0]),
      .append_pos (len_ff),
      .head_slot  (head_slot)
   );

endmodule

`default_nettype wire

// ===== rtl/core/pclr_checker.sv =====
// port-level checks of the replacer, bound to the top level
`default_nettype none
`include "pin_count_lru_replacer_unit_defines.svh"

module pclr_checker #(
   parameter int FRAMES   = 64,
   parameter int PIN_BITS = 16,
   localparam int IDX_W    = $clog2(FRAMES),
   localparam int LEN_W    = $clog2(FRAMES + 1),
   localparam int RSP_BITS = IDX_W + PIN_BITS + LEN_W + 4,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8,
   localparam int NF_POS   = IDX_W,
   localparam int PIN_LO   = IDX_W + 1,
   localparam int LEN_LO   = PIN_LO + PIN_BITS + 1,
   localparam int IGN_POS  = LEN_LO + LEN_W
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   logic                req_fire;
   logic                rsp_stall;
   logic                rsp_ign;
   logic                rsp_nf;
   logic [PIN_BITS-1:0] rsp_pins;
   logic [LEN_W-1:0]    rsp_len;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_ign   = rsp_tvalid && rsp_tdata[IGN_POS];
   assign rsp_nf    = rsp_tdata[NF_POS];
   assign rsp_pins  = rsp_tdata[PIN_LO +: PIN_BITS];
   assign rsp_len   = rsp_tdata[LEN_LO +: LEN_W];

   `PCLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result moved")

   `PCLR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_tready, "second transaction taken")

   `PCLR_ASSERT_NOW(a_busy_while_rsp, clock, reset, rsp_tvalid, !req_tready, "request taken in result")

   `PCLR_ASSERT_NOW(a_ignored_clean, clock, reset, rsp_ign, (rsp_pins == '0) && !rsp_nf, "ignored with count")

   `PCLR_ASSERT_NOW(a_len_bound, clock, reset, rsp_tvalid, rsp_len <= LEN_W'(FRAMES), "length over pool")

endmodule

bind pin_count_lru_replacer_unit pclr_checker #(
   .FRAMES   (FRAMES),
   .PIN_BITS (PIN_BITS)
) u_pclr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
